### hdl/indexed_list_store_defines.svh
// Assertion macros used by the port-level checker of the indexed list store.
`ifndef INDEXED_LIST_STORE_DEFINES_SVH
`define INDEXED_LIST_STORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ILS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// Next-cycle implication, disabled during reset.
`define ILS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

### hdl/ils_pkg.sv
// Shared constants and types of the indexed list store.
`default_nettype none
package ils_pkg;

   localparam int CAPACITY_DEF = 16;

   localparam int KIND_W  = 3;
   localparam int POS_W   = 5;
   localparam int VALUE_W = 32;
   localparam int LEN_W   = 5;

   localparam logic [KIND_W-1:0] KIND_READ       = 3'd0;
   localparam logic [KIND_W-1:0] KIND_INS_HEAD   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_INS_TAIL   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_INS_AT     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DELETE     = 3'd4;

   localparam logic [VALUE_W-1:0] READ_MISS = {VALUE_W{1'b1}};

   typedef struct packed {
      logic load_item;   // capture the accepted word
      logic execute;     // apply the operation and load the result register
   } ils_cmd_type;

endpackage
`default_nettype wire

### hdl/ils_ctrl.sv
// Controller of the indexed list store: sequences accept, execute and result hand-off.
`default_nettype none
module ils_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output ils_pkg::ils_cmd_type    cmd
);
   import ils_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic fire;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   // result register free now or emptied at this edge
   assign fire = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      cmd.load_item = 1'b0;
      cmd.execute   = 1'b0;
      state_in      = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (fire) begin
               cmd.execute = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (fire) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

### hdl/ils_datapath.sv
// Datapath of the indexed list store: slot row with shift enables, count and result register.
`default_nettype none
module ils_datapath #(
   parameter int CAPACITY = ils_pkg::CAPACITY_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire ils_pkg::ils_cmd_type         cmd,
   input  wire logic [ils_pkg::KIND_W-1:0]   req_kind,
   input  wire logic [ils_pkg::POS_W-1:0]    req_position,
   input  wire logic [ils_pkg::VALUE_W-1:0]  req_value,
   output logic [ils_pkg::VALUE_W-1:0]       rsp_read_value,
   output logic                              rsp_ok,
   output logic [ils_pkg::LEN_W-1:0]         rsp_length
);
   import ils_pkg::*;

   localparam int CW     = $clog2(CAPACITY + 1);
   localparam int CMPW   = (CW > POS_W) ? CW : POS_W;
   localparam int RDEPTH = (CAPACITY < (1 << POS_W)) ? CAPACITY : (1 << POS_W);
   localparam int RIW    = $clog2(RDEPTH);

   logic [KIND_W-1:0]  kind_ff;
   logic [POS_W-1:0]   pos_ff;
   logic [VALUE_W-1:0] value_ff;

   logic [VALUE_W-1:0] slots_ff [CAPACITY];
   logic [VALUE_W-1:0] slots_in [CAPACITY];
   logic [VALUE_W-1:0] rd_row   [RDEPTH];
   logic [CW-1:0]      count_ff, count_in;

   logic [VALUE_W-1:0] rd_value_ff, rd_value_in;
   logic               ok_ff, ok_in;
   logic [LEN_W-1:0]   len_ff;

   logic [CMPW-1:0] count_w, pos_w, ins_pos, count_next_w;
   logic is_insert, full, ins_ok, del_ok, rd_ok;

   // slots a position can ever reach
   for (genvar g = 0; g < RDEPTH; g++) begin : g_rd
      assign rd_row[g] = slots_ff[g];
   end

   assign count_w   = CMPW'(count_ff);
   assign pos_w     = CMPW'(pos_ff);
   assign full      = (count_w == CMPW'(CAPACITY));
   assign is_insert = (kind_ff == KIND_INS_HEAD) || (kind_ff == KIND_INS_TAIL)
                      || (kind_ff == KIND_INS_AT);
   assign ins_ok    = is_insert && !full && (ins_pos <= count_w);
   assign del_ok    = (kind_ff == KIND_DELETE) && (pos_w < count_w);
   assign rd_ok     = (kind_ff == KIND_READ) && (pos_w < count_w);

   always_comb begin
      case (kind_ff)
         KIND_INS_HEAD: ins_pos = '0;
         KIND_INS_TAIL: ins_pos = count_w;
         default:       ins_pos = pos_w;
      endcase
   end

   always_comb begin
      count_next_w = count_w;
      if (ins_ok) count_next_w = count_w + CMPW'(1);
      else if (del_ok) count_next_w = count_w - CMPW'(1);
   end
   assign count_in = count_next_w[CW-1:0];

   // per-slot shift enables: insert moves the tail up, delete pulls it down
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         slots_in[i] = slots_ff[i];
         if (ins_ok) begin
            if (CMPW'(i) == ins_pos) slots_in[i] = value_ff;
            else if (i > 0 && CMPW'(i) > ins_pos) slots_in[i] = slots_ff[(i > 0) ? i - 1 : 0];
         end else if (del_ok) begin
            if (i < CAPACITY - 1 && CMPW'(i) >= pos_w)
               slots_in[i] = slots_ff[(i < CAPACITY - 1) ? i + 1 : i];
         end
      end
   end

   always_comb begin
      rd_value_in = '0;
      ok_in       = ins_ok || del_ok || rd_ok;
      if (kind_ff == KIND_READ)
         rd_value_in = rd_ok ? rd_row[pos_ff[RIW-1:0]] : READ_MISS;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         kind_ff  <= req_kind;
         pos_ff   <= req_position;
         value_ff <= req_value;
      end
      if (cmd.execute) begin
         slots_ff    <= slots_in;
         rd_value_ff <= rd_value_in;
         ok_ff       <= ok_in;
         len_ff      <= count_next_w[LEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.execute) begin
         count_ff <= count_in;
      end
   end

   assign rsp_read_value = rd_value_ff;
   assign rsp_ok         = ok_ff;
   assign rsp_length     = len_ff;

endmodule
`default_nettype wire

### hdl/indexed_list_store.sv
// Timing: an accepted word is captured, then executed from the execute state once the result
//   register is free or drains at that edge; the result register then holds it as valid.
// Flow: the controller takes a new word only after the last one has executed, via its accept
//   and execute states; a waiting result holds the word in execute and stalls the request side.
// Reset: synchronous, active high; clears the element count and the handshake state.
//   Slot contents are not cleared and need no clearing pass.
`default_nettype none
module indexed_list_store #(
   parameter int CAPACITY = ils_pkg::CAPACITY_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // [4:0] position, [36:5] value, [39:37] zero
   input  wire logic [7:0]  req_tuser,   // [2:0] kind, [7:3] zero
   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata    // [31:0] read_value, [32] ok, [37:33] length, [39:38] zero
);
   import ils_pkg::*;

   ils_cmd_type         cmd;
   logic [VALUE_W-1:0]  rd_value;
   logic                ok;
   logic [LEN_W-1:0]    len;

   // control: accept one word, execute once the result register can take it
   ils_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // datapath: hold the item, shift the slot row, register the result
   ils_datapath #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_kind       (req_tuser[KIND_W-1:0]),
      .req_position   (req_tdata[POS_W-1:0]),
      .req_value      (req_tdata[POS_W +: VALUE_W]),
      .rsp_read_value (rd_value),
      .rsp_ok         (ok),
      .rsp_length     (len)
   );

   // pack the result word, pad to whole bytes
   assign rsp_tdata = {2'b00, len, ok, rd_value};

endmodule
`default_nettype wire

### hdl/ils_checker.sv
// Port-level checks of the indexed list store and their bind to the top level.
`default_nettype none
`include "indexed_list_store_defines.svh"
module ils_checker #(
   parameter int CAPACITY = ils_pkg::CAPACITY_DEF
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata
);
   import ils_pkg::*;

   // a stalled result word holds
   `ILS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   // one word in flight: no accept in the cycle after an accept
   `ILS_ASSERT_NEXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready)
   // a nonzero value without ok can only be the read miss marker
   `ILS_ASSERT_NOW(a_miss_marker, clock, reset, rsp_tvalid && !rsp_tdata[32] && (rsp_tdata[31:0] != '0), rsp_tdata[31:0] == READ_MISS)
   // length never exceeds the capacity where five bits can show it
   `ILS_ASSERT_NOW(a_len_bound, clock, reset, rsp_tvalid, (CAPACITY > 31) || (32'(rsp_tdata[37:33]) <= CAPACITY))

endmodule

bind indexed_list_store ils_checker #(
   .CAPACITY (CAPACITY)
) u_ils_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
